/* design/med_pkg.sv */
// ============================================================================
// med_pkg: shared types and constants of the envelope deframer
// Item and configuration structs, field tags, status codes, register indexes.
// ============================================================================
`default_nettype none

package med_pkg;

    // Register indexes on the configuration port
    localparam logic [7:0] CFG_IDX_VERSION_ONE = 8'd0;
    localparam logic [7:0] CFG_IDX_VERSION_TWO = 8'd1;
    localparam logic [7:0] CFG_IDX_MAX_ATTR    = 8'd2;
    localparam logic [7:0] CFG_IDX_MAX_FRAME   = 8'd3;

    // Register reset values
    localparam logic [7:0]  RST_VERSION_ONE = 8'd1;
    localparam logic [7:0]  RST_VERSION_TWO = 8'd2;
    localparam logic [15:0] RST_MAX_ATTR    = 16'd4096;
    localparam logic [24:0] RST_MAX_FRAME   = 25'd16777216;

    // Field tags
    localparam logic [4:0] FC_MAGIC      = 5'd0;
    localparam logic [4:0] FC_VERSION    = 5'd1;
    localparam logic [4:0] FC_SEQUENCE   = 5'd2;
    localparam logic [4:0] FC_TIMESTAMP  = 5'd3;
    localparam logic [4:0] FC_MSG_ID     = 5'd4;
    localparam logic [4:0] FC_TRACE_ID   = 5'd5;
    localparam logic [4:0] FC_PARENT_ID  = 5'd6;
    localparam logic [4:0] FC_TYPE_LEN   = 5'd7;
    localparam logic [4:0] FC_TYPE_TEXT  = 5'd8;
    localparam logic [4:0] FC_TRACE_LEN  = 5'd9;
    localparam logic [4:0] FC_TRACE_TEXT = 5'd10;
    localparam logic [4:0] FC_ATTR_COUNT = 5'd11;
    localparam logic [4:0] FC_KEY_LEN    = 5'd12;
    localparam logic [4:0] FC_KEY_TEXT   = 5'd13;
    localparam logic [4:0] FC_VAL_LEN    = 5'd14;
    localparam logic [4:0] FC_VAL_TEXT   = 5'd15;
    localparam logic [4:0] FC_PAY_LEN    = 5'd16;
    localparam logic [4:0] FC_PAY_BYTES  = 5'd17;
    localparam logic [4:0] FC_TRAILING   = 5'd18;
    localparam logic [4:0] FC_DISCARD    = 5'd19;

    // Status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_ACCEPTED    = 4'd1;
    localparam logic [3:0] ST_BAD_MAGIC   = 4'd2;
    localparam logic [3:0] ST_BAD_VERSION = 4'd3;
    localparam logic [3:0] ST_ZERO_ID     = 4'd4;
    localparam logic [3:0] ST_ATTRIBUTES  = 4'd5;
    localparam logic [3:0] ST_TRUNCATED   = 4'd6;
    localparam logic [3:0] ST_TRAILING    = 4'd7;
    localparam logic [3:0] ST_TOO_LONG    = 4'd8;

    // Frame constants
    localparam logic [7:0]  MAGIC_0     = 8'h47;  // 'G'
    localparam logic [7:0]  MAGIC_1     = 8'h58;  // 'X'
    localparam logic [7:0]  MAGIC_2     = 8'h45;  // 'E'
    localparam logic [4:0]  FIXED_BYTES = 5'd8;
    localparam logic [4:0]  ID_BYTES    = 5'd16;
    localparam logic [31:0] LEN_BYTES   = 32'd4;
    localparam logic [24:0] COUNT_MAX   = 25'h1FFFFFF;

    typedef struct packed {
        logic [7:0]  version_one_code;
        logic [7:0]  version_two_code;
        logic [15:0] max_attributes;
        logic [24:0] max_frame_bytes;
    } med_cfg_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [7:0]  data_out;
        logic [23:0] byte_index;
        logic        frame_end;
        logic [3:0]  status;
    } med_item_t;

endpackage

`default_nettype wire

/* design/med_front.sv */
// ============================================================================
// med_front: envelope parser
// Accept one byte per cycle unless the queue is full; track the frame layout and tag each byte.
// ============================================================================
`default_nettype none

module med_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire med_pkg::med_cfg_t  cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire logic               q_full,
    output logic                    push,
    output med_pkg::med_item_t      push_item
);

    typedef enum logic [21:0] {
        PH_MAGIC0    = 22'h000001,
        PH_MAGIC1    = 22'h000002,
        PH_MAGIC2    = 22'h000004,
        PH_VERSION   = 22'h000008,
        PH_SEQ       = 22'h000010,
        PH_TIME      = 22'h000020,
        PH_ID_MSG    = 22'h000040,
        PH_ID_TRACE  = 22'h000080,
        PH_ID_PARENT = 22'h000100,
        PH_TYPE_LEN  = 22'h000200,
        PH_TYPE_STR  = 22'h000400,
        PH_TRACE_LEN = 22'h000800,
        PH_TRACE_STR = 22'h001000,
        PH_COUNT     = 22'h002000,
        PH_KEY_LEN   = 22'h004000,
        PH_KEY_STR   = 22'h008000,
        PH_VAL_LEN   = 22'h010000,
        PH_VAL_STR   = 22'h020000,
        PH_PAY_LEN   = 22'h040000,
        PH_PAY_STR   = 22'h080000,
        PH_DONE      = 22'h100000,
        PH_DISCARD   = 22'h200000
    } phase_t;

    function automatic logic [4:0] phase_code(input phase_t p);
        logic [4:0] c;
        c = med_pkg::FC_DISCARD;
        unique case (p)
            PH_SEQ:       c = med_pkg::FC_SEQUENCE;
            PH_TIME:      c = med_pkg::FC_TIMESTAMP;
            PH_ID_MSG:    c = med_pkg::FC_MSG_ID;
            PH_ID_TRACE:  c = med_pkg::FC_TRACE_ID;
            PH_ID_PARENT: c = med_pkg::FC_PARENT_ID;
            PH_TYPE_LEN:  c = med_pkg::FC_TYPE_LEN;
            PH_TYPE_STR:  c = med_pkg::FC_TYPE_TEXT;
            PH_TRACE_LEN: c = med_pkg::FC_TRACE_LEN;
            PH_TRACE_STR: c = med_pkg::FC_TRACE_TEXT;
            PH_COUNT:     c = med_pkg::FC_ATTR_COUNT;
            PH_KEY_LEN:   c = med_pkg::FC_KEY_LEN;
            PH_KEY_STR:   c = med_pkg::FC_KEY_TEXT;
            PH_VAL_LEN:   c = med_pkg::FC_VAL_LEN;
            PH_VAL_STR:   c = med_pkg::FC_VAL_TEXT;
            PH_PAY_LEN:   c = med_pkg::FC_PAY_LEN;
            PH_PAY_STR:   c = med_pkg::FC_PAY_BYTES;
            default:      c = med_pkg::FC_DISCARD;
        endcase
        return c;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] attr_reg, attr_next;
    logic [24:0] count_reg, count_next;
    logic        two_reg, two_next;
    logic        trace_reg, trace_next;
    logic        idz_reg, idz_next;
    logic [3:0]  err_reg, err_next;

    logic        accept;
    logic        over;
    logic [31:0] acc_shift;
    logic [31:0] remain_dec;
    logic [15:0] attr_dec;
    logic [4:0]  fixed_size;
    logic        idz_upd;
    logic        set_err;
    logic [3:0]  err_val;
    logic        go_len;
    phase_t      len_phase;
    logic [4:0]  code;
    logic [23:0] offset;
    logic [3:0]  stat;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        acc_next    = acc_reg;
        attr_next   = attr_reg;
        two_next    = two_reg;
        trace_next  = trace_reg;
        idz_next    = idz_reg;
        err_next    = err_reg;
        code        = med_pkg::FC_DISCARD;
        offset      = 24'd0;
        stat        = med_pkg::ST_OK;
        set_err     = 1'b0;
        err_val     = med_pkg::ST_OK;
        go_len      = 1'b0;
        len_phase   = PH_TYPE_LEN;

        count_next = (count_reg < med_pkg::COUNT_MAX) ? count_reg + 25'd1 : count_reg;
        over       = count_next > cfg.max_frame_bytes;
        acc_shift  = {acc_reg[23:0], data_byte};
        remain_dec = (remain_reg != 32'd0) ? remain_reg - 32'd1 : remain_reg;
        attr_dec   = (attr_reg != 16'd0) ? attr_reg - 16'd1 : attr_reg;
        fixed_size = (phase_reg == PH_SEQ || phase_reg == PH_TIME) ?
                     med_pkg::FIXED_BYTES : med_pkg::ID_BYTES;
        idz_upd    = idz_reg && (data_byte == 8'd0);

        if (err_reg == med_pkg::ST_OK && over)
        begin
            set_err = 1'b1;
            err_val = med_pkg::ST_TOO_LONG;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_MAGIC0:
                begin
                    code = med_pkg::FC_MAGIC;
                    offset = 24'd0;
                    if (data_byte != med_pkg::MAGIC_0)
                    begin
                        set_err = 1'b1;
                        err_val = med_pkg::ST_BAD_MAGIC;
                    end
                    else
                        phase_next = PH_MAGIC1;
                end
                PH_MAGIC1:
                begin
                    code = med_pkg::FC_MAGIC;
                    offset = 24'd1;
                    if (data_byte != med_pkg::MAGIC_1)
                    begin
                        set_err = 1'b1;
                        err_val = med_pkg::ST_BAD_MAGIC;
                    end
                    else
                        phase_next = PH_MAGIC2;
                end
                PH_MAGIC2:
                begin
                    code = med_pkg::FC_MAGIC;
                    offset = 24'd2;
                    if (data_byte != med_pkg::MAGIC_2)
                    begin
                        set_err = 1'b1;
                        err_val = med_pkg::ST_BAD_MAGIC;
                    end
                    else
                        phase_next = PH_VERSION;
                end
                PH_VERSION:
                begin
                    code = med_pkg::FC_VERSION;
                    trace_next = (data_byte == cfg.version_one_code);
                    two_next   = (data_byte == cfg.version_two_code);
                    if (!trace_next && !two_next)
                    begin
                        set_err = 1'b1;
                        err_val = med_pkg::ST_BAD_VERSION;
                    end
                    else
                    begin
                        phase_next  = PH_SEQ;
                        remain_next = 32'(med_pkg::FIXED_BYTES);
                    end
                end
                PH_SEQ, PH_TIME, PH_ID_MSG, PH_ID_TRACE, PH_ID_PARENT:
                begin
                    code = phase_code(phase_reg);
                    offset = 24'(fixed_size - remain_reg[4:0]);
                    idz_next = idz_upd;
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        if ((phase_reg == PH_ID_MSG || phase_reg == PH_ID_TRACE) && idz_upd)
                        begin
                            set_err = 1'b1;
                            err_val = med_pkg::ST_ZERO_ID;
                        end
                        else if (phase_reg == PH_SEQ)
                        begin
                            phase_next  = PH_TIME;
                            remain_next = 32'(med_pkg::FIXED_BYTES);
                        end
                        else if (phase_reg == PH_TIME && two_reg)
                        begin
                            phase_next  = PH_ID_MSG;
                            remain_next = 32'(med_pkg::ID_BYTES);
                            idz_next    = 1'b1;
                        end
                        else if (phase_reg == PH_ID_MSG || phase_reg == PH_ID_TRACE)
                        begin
                            phase_next  = (phase_reg == PH_ID_MSG) ? PH_ID_TRACE : PH_ID_PARENT;
                            remain_next = 32'(med_pkg::ID_BYTES);
                            idz_next    = 1'b1;
                        end
                        else
                        begin
                            go_len    = 1'b1;
                            len_phase = PH_TYPE_LEN;
                        end
                    end
                end
                PH_TYPE_LEN, PH_TRACE_LEN, PH_COUNT, PH_KEY_LEN, PH_VAL_LEN, PH_PAY_LEN:
                begin
                    code = phase_code(phase_reg);
                    offset = 24'(med_pkg::LEN_BYTES - remain_reg);
                    acc_next = acc_shift;
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        if (phase_reg == PH_COUNT)
                        begin
                            if (acc_shift > {16'd0, cfg.max_attributes})
                            begin
                                set_err = 1'b1;
                                err_val = med_pkg::ST_ATTRIBUTES;
                            end
                            else
                            begin
                                attr_next = acc_shift[15:0];
                                go_len    = 1'b1;
                                len_phase = (acc_shift != 32'd0) ? PH_KEY_LEN : PH_PAY_LEN;
                            end
                        end
                        else if (acc_shift != 32'd0)
                        begin
                            // enter the text that follows this length
                            remain_next = acc_shift;
                            unique case (phase_reg)
                                PH_TYPE_LEN:  phase_next = PH_TYPE_STR;
                                PH_TRACE_LEN: phase_next = PH_TRACE_STR;
                                PH_KEY_LEN:   phase_next = PH_KEY_STR;
                                PH_VAL_LEN:   phase_next = PH_VAL_STR;
                                default:      phase_next = PH_PAY_STR;
                            endcase
                        end
                        else
                        begin
                            // empty text: skip straight past it
                            go_len = 1'b1;
                            unique case (phase_reg)
                                PH_TYPE_LEN:  len_phase = trace_reg ? PH_TRACE_LEN : PH_COUNT;
                                PH_TRACE_LEN: len_phase = PH_COUNT;
                                PH_KEY_LEN:   len_phase = PH_VAL_LEN;
                                PH_VAL_LEN:
                                begin
                                    attr_next = attr_dec;
                                    len_phase = (attr_dec != 16'd0) ? PH_KEY_LEN : PH_PAY_LEN;
                                end
                                default:
                                begin
                                    go_len      = 1'b0;
                                    phase_next  = PH_DONE;
                                    remain_next = 32'd0;
                                end
                            endcase
                        end
                    end
                end
                PH_TYPE_STR, PH_TRACE_STR, PH_KEY_STR, PH_VAL_STR, PH_PAY_STR:
                begin
                    code = phase_code(phase_reg);
                    offset = 24'(acc_reg - remain_reg);
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        go_len = 1'b1;
                        unique case (phase_reg)
                            PH_TYPE_STR:  len_phase = trace_reg ? PH_TRACE_LEN : PH_COUNT;
                            PH_TRACE_STR: len_phase = PH_COUNT;
                            PH_KEY_STR:   len_phase = PH_VAL_LEN;
                            PH_VAL_STR:
                            begin
                                attr_next = attr_dec;
                                len_phase = (attr_dec != 16'd0) ? PH_KEY_LEN : PH_PAY_LEN;
                            end
                            default:
                            begin
                                go_len      = 1'b0;
                                phase_next  = PH_DONE;
                                remain_next = 32'd0;
                            end
                        endcase
                    end
                end
                PH_DONE:
                begin
                    code = med_pkg::FC_TRAILING;
                    set_err = 1'b1;
                    err_val = med_pkg::ST_TRAILING;
                end
                default:
                begin
                    code = med_pkg::FC_DISCARD;
                end
            endcase
        end

        if (go_len)
        begin
            phase_next  = len_phase;
            remain_next = med_pkg::LEN_BYTES;
            acc_next    = 32'd0;
        end

        if (set_err)
        begin
            err_next    = err_val;
            phase_next  = PH_DISCARD;
            remain_next = 32'd0;
        end

        if (last_byte)
        begin
            if (over)
                stat = med_pkg::ST_TOO_LONG;
            else if (err_next != med_pkg::ST_OK)
                stat = err_next;
            else if (phase_next == PH_DONE)
                stat = med_pkg::ST_ACCEPTED;
            else
                stat = med_pkg::ST_TRUNCATED;
            // return to the idle frame state
            phase_next  = PH_MAGIC0;
            remain_next = 32'd0;
            acc_next    = 32'd0;
            attr_next   = 16'd0;
            count_next  = 25'd0;
            two_next    = 1'b0;
            trace_next  = 1'b0;
            idz_next    = 1'b1;
            err_next    = med_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC0;
            remain_reg <= 32'd0;
            acc_reg    <= 32'd0;
            attr_reg   <= 16'd0;
            count_reg  <= 25'd0;
            two_reg    <= 1'b0;
            trace_reg  <= 1'b0;
            idz_reg    <= 1'b1;
            err_reg    <= med_pkg::ST_OK;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
            attr_reg   <= attr_next;
            count_reg  <= count_next;
            two_reg    <= two_next;
            trace_reg  <= trace_next;
            idz_reg    <= idz_next;
            err_reg    <= err_next;
        end
    end

    assign push                 = accept;
    assign push_item.field_code = code;
    assign push_item.data_out   = data_byte;
    assign push_item.byte_index = offset;
    assign push_item.frame_end  = last_byte;
    assign push_item.status     = stat;

endmodule

`default_nettype wire

/* design/med_queue.sv */
// ============================================================================
// med_queue: tagged item queue
// Short FIFO that decouples the parser from the output stage.
// ============================================================================
`default_nettype none

module med_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire med_pkg::med_item_t  push_item,
    input  wire logic                pop,
    output logic                     full,
    output logic                     head_valid,
    output med_pkg::med_item_t       head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    med_pkg::med_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

/* design/med_back.sv */
// ============================================================================
// med_back: result output stage
// Register the head of the queue and hold it while the receiver stalls.
// ============================================================================
`default_nettype none

module med_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire med_pkg::med_item_t  head_item,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output med_pkg::med_item_t       out_item
);

    logic               valid_reg, valid_next;
    med_pkg::med_item_t item_reg;

    // load when the register is empty or its item leaves this cycle
    assign pop        = head_valid && (!valid_reg || !out_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head_item;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

/* design/message_envelope_deframer.sv */
// ============================================================================
// message_envelope_deframer: message envelope parser, one byte per item
// Tags each frame byte with its envelope field and reports the frame status.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): one frame byte per item, with
//   last_byte set on the final byte of a frame. Output channel (out_valid /
//   out_stall): one tagged item per input byte, carrying field_code, the byte
//   itself, its offset within the field, frame_end and, on the frame's last
//   byte, the final status (too long if over the limit, else accepted or the first error found).
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; write only while no frame byte is in flight. Indexes beyond
//   the register list are ignored.
//   Throughput: one byte per cycle while in_stall is low; the parser
//   updates its phase and counters in the cycle an item is accepted.
//   Path: each accepted byte enters the queue, then the output register.
//   Stall: the output register holds its item while out_stall is high; the
//   queue behind it absorbs items until full, then in_stall rises.
//   Reset: registers return to their default values, the parser expects the
//   first magic byte and the queue and output stage are empty.
// ============================================================================
`default_nettype none

module message_envelope_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [24:0] cfg_data,
    // input byte channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       field_code,
    output logic [7:0]       data_out,
    output logic [23:0]      byte_index,
    output logic             frame_end,
    output logic [3:0]       status
);

    med_pkg::med_cfg_t  cfg_reg;
    med_pkg::med_item_t push_item;
    med_pkg::med_item_t head_item;
    med_pkg::med_item_t out_item;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               head_valid;

    // Registers take a write in any cycle; the parser reads them directly.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.version_one_code <= med_pkg::RST_VERSION_ONE;
            cfg_reg.version_two_code <= med_pkg::RST_VERSION_TWO;
            cfg_reg.max_attributes   <= med_pkg::RST_MAX_ATTR;
            cfg_reg.max_frame_bytes  <= med_pkg::RST_MAX_FRAME;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                med_pkg::CFG_IDX_VERSION_ONE: cfg_reg.version_one_code <= cfg_data[7:0];
                med_pkg::CFG_IDX_VERSION_TWO: cfg_reg.version_two_code <= cfg_data[7:0];
                med_pkg::CFG_IDX_MAX_ATTR:    cfg_reg.max_attributes   <= cfg_data[15:0];
                med_pkg::CFG_IDX_MAX_FRAME:   cfg_reg.max_frame_bytes  <= cfg_data;
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front: accept and classify each byte, update the frame state.
    med_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Queue: lets the parser run on while the receiver stalls.
    med_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back: registered output, held under stall.
    med_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

    assign field_code = out_item.field_code;
    assign data_out   = out_item.data_out;
    assign byte_index = out_item.byte_index;
    assign frame_end  = out_item.frame_end;
    assign status     = out_item.status;

endmodule

`default_nettype wire
